// ===== src/lrmp_pkg.sv =====
// shared constants and types for the linear recurrence matrix power block
package lrmp_pkg;

  localparam int MAX_ORDER  = 16;
  localparam int INDEX_BITS = 60;
  localparam int ORD_BITS   = $clog2(MAX_ORDER);
  localparam int ADDR_BITS  = 2 * ORD_BITS;
  localparam int VAL_BITS   = 30;
  localparam logic [VAL_BITS-1:0] PRIME = 30'd1000000007;
  // barrett reciprocal, floor(2^60 / prime)
  localparam logic [VAL_BITS:0] BARRETT_MU =
    (VAL_BITS+1)'((64'd1 << (2*VAL_BITS)) / 64'(PRIME));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_CHECK,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_RED,
    ST_MAC_QP,
    ST_MAC_ACC,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DONE
  } state_t;

endpackage

// ===== src/linear_recurrence_matrix_power_mod.sv =====
// linear recurrence term by modular matrix power, one shared modular mac unit
module linear_recurrence_matrix_power_mod (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [lrmp_pkg::INDEX_BITS-1:0]   n_index,
  output logic                              done,
  output logic [lrmp_pkg::VAL_BITS-1:0]     term_value,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [0:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  // An item is taken when start is high and busy is low; the term appears on
  // term_value for one cycle with done high and must be taken then. For n
  // below the order done is high in the cycle right after the transfer.
  // Otherwise the time is set by the single modular mac unit working on the
  // matrices in memory: each multiply-accumulate step runs through read,
  // multiply, two barrett reduction steps and accumulate, each matrix product
  // is followed by a copy back, and there are up to 2*bitlength(n) products.
  // No clearing pass is needed after reset.
  import lrmp_pkg::*;

  localparam logic [ORD_BITS:0] MAX_M = (ORD_BITS+1)'(MAX_ORDER);
  localparam logic [31:0] PRIME1 = {2'b00, PRIME};
  localparam logic [31:0] PRIME2 = {1'b0, PRIME, 1'b0};

  // configuration register
  logic [4:0] order_m;
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {27'd0, order_m} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      order_m <= 5'd2;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      order_m <= pwdata[4:0];
    end
  end

  // effective order, saturated
  logic [ORD_BITS:0] m_eff;
  always_comb begin
    if (order_m < 5'd2) m_eff = (ORD_BITS+1)'(2);
    else if ({1'b0, order_m} > 6'(MAX_ORDER)) m_eff = MAX_M;
    else m_eff = (ORD_BITS+1)'(order_m);
  end

  // matrix memories: result, base, scratch
  logic [VAL_BITS-1:0] res_mem [MAX_ORDER*MAX_ORDER];
  logic [VAL_BITS-1:0] base_mem [MAX_ORDER*MAX_ORDER];
  logic [VAL_BITS-1:0] scr_mem [MAX_ORDER*MAX_ORDER];

  state_t state, state_next;
  logic [INDEX_BITS-1:0] exp_left;
  logic                  mul_res;      // current product goes to result
  logic [ORD_BITS-1:0]   r, c, k;
  logic [VAL_BITS-1:0]   acc;
  logic [VAL_BITS-1:0]   lhs_q, rhs_q, scr_q, res_q;
  logic [2*VAL_BITS-1:0] prod;         // product plus running sum
  logic [VAL_BITS-1:0]   q_est;        // barrett quotient estimate
  logic [31:0]           part_rem;     // remainder below three primes
  logic [2*VAL_BITS+1:0] q_wide;
  logic [31:0]           qp_low;
  logic [VAL_BITS-1:0]   red;
  logic [31:0]           sum;

  logic [ORD_BITS-1:0] m_last;
  assign m_last = ORD_BITS'(m_eff - 1'b1);

  logic [ADDR_BITS-1:0] a_lhs, a_rhs, a_rc, a_sum;
  assign a_lhs = {r, k};
  assign a_rhs = {k, c};
  assign a_rc  = {r, c};
  assign a_sum = {{ORD_BITS{1'b0}}, c};

  // barrett reduction pieces
  assign q_wide = {31'd0, prod[2*VAL_BITS-1:VAL_BITS-1]} * {31'd0, BARRETT_MU};
  assign qp_low = {2'b00, q_est} * PRIME1;
  always_comb begin
    if (part_rem >= PRIME2) red = VAL_BITS'(part_rem - PRIME2);
    else if (part_rem >= PRIME1) red = VAL_BITS'(part_rem - PRIME1);
    else red = part_rem[VAL_BITS-1:0];
  end

  // memory reads, registered
  always_ff @(posedge clk) begin
    lhs_q <= mul_res ? res_mem[a_lhs] : base_mem[a_lhs];
    rhs_q <= base_mem[a_rhs];
    scr_q <= scr_mem[a_rc];
    res_q <= res_mem[a_sum];
  end

  // init value of the companion matrix and identity
  logic [VAL_BITS-1:0] b_init, i_init;
  always_comb begin
    b_init = '0;
    if (r == '0 && (c == '0 || c == m_last)) b_init = VAL_BITS'(1);
    if (r != '0 && c == ORD_BITS'(r - 1'b1)) b_init = VAL_BITS'(1);
    i_init = (r == c) ? VAL_BITS'(1) : '0;
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (state == ST_INIT) begin
      base_mem[a_rc] <= b_init;
      res_mem[a_rc]  <= i_init;
    end
    if (state == ST_MAC_ACC && k == m_last) begin
      scr_mem[a_rc] <= red;
    end
    if (state == ST_COPY_WR) begin
      if (mul_res) res_mem[a_rc] <= scr_q;
      else base_mem[a_rc] <= scr_q;
    end
  end

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      exp_left <= '0;
      acc      <= '0;
      mul_res  <= 1'b0;
      r <= '0; c <= '0; k <= '0;
      sum <= '0;
      prod <= '0;
      q_est <= '0;
      part_rem <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            exp_left <= n_index - INDEX_BITS'(m_last);
            r <= '0; c <= '0; k <= '0;
            sum <= (n_index < INDEX_BITS'(m_eff)) ? 32'd1 : 32'd0;
          end
        end
        ST_INIT: begin
          if (c == m_last && r == m_last) begin
            r <= '0; c <= '0;
            mul_res <= exp_left[0];
          end else if (c == m_last) begin
            c <= '0;
            r <= ORD_BITS'(r + 1'b1);
          end else begin
            c <= ORD_BITS'(c + 1'b1);
          end
        end
        ST_CHECK: begin
          r <= '0; c <= '0; k <= '0; acc <= '0;
        end
        ST_MAC_MUL: prod <= ({VAL_BITS'(0), lhs_q} * {VAL_BITS'(0), rhs_q}) +
                            {VAL_BITS'(0), acc};
        ST_MAC_RED: q_est <= q_wide[2*VAL_BITS:VAL_BITS+1];
        ST_MAC_QP:  part_rem <= prod[31:0] - qp_low;
        ST_MAC_ACC: begin
          acc <= (k == m_last) ? '0 : red;
          if (k == m_last) begin
            k <= '0;
            if (c == m_last) begin
              c <= '0;
              r <= (r == m_last) ? '0 : ORD_BITS'(r + 1'b1);
            end else begin
              c <= ORD_BITS'(c + 1'b1);
            end
          end else begin
            k <= ORD_BITS'(k + 1'b1);
          end
        end
        ST_COPY_WR: begin
          if (c == m_last) begin
            c <= '0;
            r <= (r == m_last) ? '0 : ORD_BITS'(r + 1'b1);
          end else begin
            c <= ORD_BITS'(c + 1'b1);
          end
          if (c == m_last && r == m_last) begin
            if (mul_res) begin
              mul_res <= 1'b0;
            end else begin
              exp_left <= exp_left >> 1;
              mul_res  <= exp_left[1];
            end
          end
        end
        ST_SUM_ACC: begin
          sum <= (32'(sum) + 32'(res_q) >= 32'(PRIME)) ?
                 sum + 32'(res_q) - 32'(PRIME) : sum + 32'(res_q);
          c <= ORD_BITS'(c + 1'b1);
        end
        ST_DONE: sum <= sum;
        default: ;
      endcase
    end
  end

  // next state and outputs
  always_comb begin
    state_next = state;
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
    term_value = sum[VAL_BITS-1:0];
    unique case (state)
      ST_IDLE: if (start) state_next = (n_index < INDEX_BITS'(m_eff)) ? ST_DONE : ST_INIT;
      ST_INIT: if (c == m_last && r == m_last) state_next = ST_CHECK;
      ST_CHECK: state_next = (exp_left == '0) ? ST_SUM_RD : ST_MAC_RD;
      ST_MAC_RD: state_next = ST_MAC_MUL;
      ST_MAC_MUL: state_next = ST_MAC_RED;
      ST_MAC_RED: state_next = ST_MAC_QP;
      ST_MAC_QP: state_next = ST_MAC_ACC;
      ST_MAC_ACC: begin
        if (k == m_last && c == m_last && r == m_last) state_next = ST_COPY_RD;
        else state_next = ST_MAC_RD;
      end
      ST_COPY_RD: state_next = ST_COPY_WR;
      ST_COPY_WR: begin
        if (c == m_last && r == m_last) state_next = ST_CHECK;
        else state_next = ST_COPY_RD;
      end
      ST_SUM_RD: state_next = ST_SUM_ACC;
      ST_SUM_ACC: state_next = (c == m_last) ? ST_DONE : ST_SUM_RD;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
